### rtl/fm_channel_pitch_effects_assert.svh
// Assertion helpers for the pitch effect engine.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef FM_CHANNEL_PITCH_EFFECTS_ASSERT_SVH
`define FM_CHANNEL_PITCH_EFFECTS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FMCPE_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fmcpe: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define FMCPE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fmcpe: next-cycle check failed");

`endif

### rtl/fmcpe_pkg.sv
package fmcpe_pkg;

    // Request kinds
    typedef enum logic [2:0] {
        KIND_TICK       = 3'd0,
        KIND_SET_FREQ   = 3'd1,
        KIND_KEY_ON     = 3'd2,
        KIND_KEY_OFF    = 3'd3,
        KIND_SLIDE      = 3'd4,
        KIND_VIBRATO    = 3'd5,
        KIND_RM_SLIDE   = 3'd6,
        KIND_RM_VIBRATO = 3'd7
    } t_kind;

    // Effect mode codes (code 3 is never stored)
    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_SLIDE   = 2'd1;
    localparam logic [1:0] MODE_VIBRATO = 2'd2;

    // Synthesizer register bases
    localparam logic [7:0] REG_FREQ_BASE = 8'hA0;
    localparam logic [7:0] REG_KEY_BASE  = 8'hB0;

    // Octave renormalization bounds of the slide
    localparam logic signed [15:0] SLIDE_UP_LIMIT   = 16'sh02DE;
    localparam logic signed [15:0] SLIDE_DOWN_LIMIT = 16'sh0184;

    // Vibrato range at and above which the shift is zero
    localparam logic [7:0] VIB_RANGE_MAX = 8'd9;

    // Per-channel state word
    typedef struct packed {
        logic [7:0]  freq_low;
        logic [7:0]  key_block;
        logic [1:0]  mode;
        logic [7:0]  slide_rate;
        logic [7:0]  slide_phase;
        logic [15:0] slide_inc;
        logic [7:0]  vib_rate;
        logic [7:0]  vib_phase;
        logic [7:0]  vib_range;
        logic [7:0]  vib_period;
        logic [7:0]  vib_countdown;
        logic [7:0]  vib_delay;
        logic [7:0]  vib_wait;
        logic [15:0] vib_inc;
    } t_chan_state;

    localparam t_chan_state CHAN_RESET = '{slide_phase: 8'hFF, default: '0};

    // Captured request
    typedef struct packed {
        t_kind              kind;
        logic [3:0]         channel;
        logic [7:0]         param_a;
        logic [7:0]         param_b;
        logic [7:0]         param_c;
        logic [7:0]         param_d;
        logic signed [15:0] slide_step;
        logic [7:0]         fnum_low;
        logic [4:0]         block_fnum_high;
    } t_request;

    // Register writes caused by one request; a single write uses the first slot
    typedef struct packed {
        logic       first_valid;
        logic [7:0] first_addr;
        logic [7:0] first_value;
        logic       second_valid;
        logic [7:0] second_addr;
        logic [7:0] second_value;
    } t_writes;

endpackage

### rtl/fm_channel_pitch_effects.sv
// Pitch effect engine for a bank of FM synthesizer channels.
//
// Requests enter on i_start while o_busy is low; each carries a kind, a
// channel and the parameter fields of that kind. The register writes a
// request causes (zero, one or two) leave on o_reg_address / o_reg_value,
// each shown for exactly one cycle with o_result_valid; o_last marks the
// final write of a request. The receiver cannot hold results off.
// Requests for a channel at or above CHANNELS are dropped without output.
//
// Timing: the channel's state word is read from a one-port-read,
// one-port-write memory at the accepting edge, updated in the next cycle
// (ST_EXEC) and written back at its end, where the first write is also
// registered onto the ports; a second write is registered from ST_SECOND.
// o_busy stays high through ST_EXEC and ST_SECOND, so a new request is
// accepted only after the engine has returned to ST_IDLE.
//
// Reset clears the control state, the rhythm mode register and the
// per-channel written flags; all channels then read as their reset state.
// The rhythm mode register takes a write on any cycle (o_cfg_ready is high).
`include "fm_channel_pitch_effects_assert.svh"

module fm_channel_pitch_effects #(
    parameter int CHANNELS = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_kind,
    input  logic [3:0]  i_channel,
    input  logic [7:0]  i_param_a,
    input  logic [7:0]  i_param_b,
    input  logic [7:0]  i_param_c,
    input  logic [7:0]  i_param_d,
    input  logic signed [15:0] i_slide_step,
    input  logic [7:0]  i_fnum_low,
    input  logic [4:0]  i_block_fnum_high,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    output logic        o_result_valid,
    output logic [7:0]  o_reg_address,
    output logic [7:0]  o_reg_value,
    output logic        o_last
);
    import fmcpe_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [4:0] CHAN_LIMIT = 5'(CHANNELS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SECOND
    } t_state;

    t_state      r_state;
    t_request    r_req;
    logic        r_in_range;
    logic        r_rhythm_mode;
    logic        r_result_valid;
    logic [7:0]  r_reg_address;
    logic [7:0]  r_reg_value;
    logic        r_last;
    logic [7:0]  r_second_addr;
    logic [7:0]  r_second_value;

    logic        accept;
    t_chan_state rd_state;
    t_chan_state upd_state;
    t_writes     upd_writes;
    logic        first_ok;
    logic        second_ok;

    assign accept      = i_start && !o_busy;
    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Rhythm mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rhythm_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_rhythm_mode <= i_cfg_data;
        end
    end

    // Channel state memory
    fmcpe_state_mem #(
        .CHANNELS (CHANNELS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (i_channel[CH_W-1:0]),
        .o_rd_data (rd_state),
        .i_wr_en   ((r_state == ST_EXEC) && r_in_range),
        .i_wr_addr (r_req.channel[CH_W-1:0]),
        .i_wr_data (upd_state)
    );

    // Per-request update
    fmcpe_update u_update (
        .i_req         (r_req),
        .i_state       (rd_state),
        .i_rhythm_mode (r_rhythm_mode),
        .o_state       (upd_state),
        .o_writes      (upd_writes)
    );

    assign first_ok  = r_in_range && upd_writes.first_valid;
    assign second_ok = r_in_range && upd_writes.second_valid;

    // Sequence: capture request, update, emit zero, one or two writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_result_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_result_valid <= 1'b0;
                    if (accept) begin
                        r_req.kind            <= t_kind'(i_kind);
                        r_req.channel         <= i_channel;
                        r_req.param_a         <= i_param_a;
                        r_req.param_b         <= i_param_b;
                        r_req.param_c         <= i_param_c;
                        r_req.param_d         <= i_param_d;
                        r_req.slide_step      <= i_slide_step;
                        r_req.fnum_low        <= i_fnum_low;
                        r_req.block_fnum_high <= i_block_fnum_high;
                        r_in_range            <= ({1'b0, i_channel} < CHAN_LIMIT);
                        r_state               <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_result_valid <= first_ok;
                    r_reg_address  <= upd_writes.first_addr;
                    r_reg_value    <= upd_writes.first_value;
                    r_last         <= !second_ok;
                    r_second_addr  <= upd_writes.second_addr;
                    r_second_value <= upd_writes.second_value;
                    r_state        <= second_ok ? ST_SECOND : ST_IDLE;
                end
                ST_SECOND: begin
                    r_result_valid <= 1'b1;
                    r_reg_address  <= r_second_addr;
                    r_reg_value    <= r_second_value;
                    r_last         <= 1'b1;
                    r_state        <= ST_IDLE;
                end
                default: begin
                    r_result_valid <= 1'b0;
                    r_state        <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_reg_address  = r_reg_address;
    assign o_reg_value    = r_reg_value;
    assign o_last         = r_last;

    // Accepted request always occupies the engine next cycle
    `FMCPE_ASSERT_NEXT(a_accept_busy, accept, o_busy)
    // A non-final write is followed at once by the final one
    `FMCPE_ASSERT_NEXT(a_pair_follows, o_result_valid && !o_last, o_result_valid && o_last)
    // The final write of a request is never directly followed by another write
    `FMCPE_ASSERT_NEXT(a_last_gap, o_result_valid && o_last, !o_result_valid)
    // Writes target only frequency or key/block registers
    `FMCPE_ASSERT_SAME(a_addr_range, o_result_valid, o_reg_address[7:5] == 3'b101)

endmodule

### rtl/fmcpe_state_mem.sv
module fmcpe_state_mem #(
    parameter int CHANNELS = 9
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_rd_en,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_rd_addr,
    output fmcpe_pkg::t_chan_state                              o_rd_data,
    input  logic                                                i_wr_en,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_wr_addr,
    input  fmcpe_pkg::t_chan_state                              i_wr_data
);
    import fmcpe_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W:0] DEPTH = (CH_W + 1)'(CHANNELS);

    t_chan_state         r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_valid;
    t_chan_state         r_rd_data;
    logic                r_rd_valid;

    // Mark entries written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_rd_valid <= ({1'b0, i_rd_addr} < DEPTH) && r_valid[i_rd_addr];
        end
    end

    // Entries never written read as the reset state
    assign o_rd_data = r_rd_valid ? r_rd_data : CHAN_RESET;

endmodule

### rtl/fmcpe_update.sv
module fmcpe_update (
    input  fmcpe_pkg::t_request    i_req,
    input  fmcpe_pkg::t_chan_state i_state,
    input  logic                   i_rhythm_mode,
    output fmcpe_pkg::t_chan_state o_state,
    output fmcpe_pkg::t_writes     o_writes
);
    import fmcpe_pkg::*;

    logic [9:0]  freq10;
    logic [7:0]  addr_freq;
    logic [7:0]  addr_key;
    logic [8:0]  slide_sum;
    logic [15:0] slide_f;
    logic [15:0] slide_adj;
    logic [2:0]  oct_n;
    logic [8:0]  vib_sum;
    logic [7:0]  cd_dec;
    logic [15:0] vib_inc_n;
    logic [7:0]  vib_cd_n;
    logic [15:0] vib_f;
    logic [3:0]  vib_r;
    logic [3:0]  vib_shift;
    logic [9:0]  freq_shifted;
    logic [7:0]  key_on_byte;
    logic [7:0]  key_off_byte;
    logic [7:0]  set_key_byte;

    assign freq10    = {i_state.key_block[1:0], i_state.freq_low};
    assign addr_freq = REG_FREQ_BASE + {4'b0, i_req.channel};
    assign addr_key  = REG_KEY_BASE + {4'b0, i_req.channel};

    // Slide: advance phase, add step, renormalize octave
    always_comb begin
        slide_sum = {1'b0, i_state.slide_phase} + {1'b0, i_state.slide_rate};
        slide_f   = {6'b0, freq10} + i_state.slide_inc;
        slide_adj = slide_f;
        oct_n     = i_state.key_block[4:2];
        if (!i_state.slide_inc[15] && ($signed(slide_f) >= SLIDE_UP_LIMIT)) begin
            slide_adj = slide_f >> 1;
            oct_n     = i_state.key_block[4:2] + 3'd1;
        end else if (i_state.slide_inc[15] && ($signed(slide_f) <= SLIDE_DOWN_LIMIT)) begin
            slide_adj = slide_f << 1;
            oct_n     = i_state.key_block[4:2] - 3'd1;
        end
    end

    // Vibrato: advance phase, count down half period, flip step direction
    always_comb begin
        vib_sum   = {1'b0, i_state.vib_phase} + {1'b0, i_state.vib_rate};
        cd_dec    = i_state.vib_countdown - 8'd1;
        vib_inc_n = i_state.vib_inc;
        vib_cd_n  = cd_dec;
        if (cd_dec == 8'd0) begin
            vib_inc_n = 16'd0 - i_state.vib_inc;
            vib_cd_n  = i_state.vib_period;
        end
        vib_f = {6'b0, freq10} + vib_inc_n;
    end

    // Key on: vibrato step from frequency scaled by range; key on/off and set-frequency key bytes
    always_comb begin
        vib_r        = (i_state.vib_range < VIB_RANGE_MAX) ? i_state.vib_range[3:0]
                                                           : VIB_RANGE_MAX[3:0];
        vib_shift    = VIB_RANGE_MAX[3:0] - vib_r;
        freq_shifted = freq10 >> vib_shift;
        key_on_byte  = i_state.key_block | 8'h20;
        key_off_byte = i_state.key_block & 8'hDF;
        set_key_byte = {2'b0, i_state.key_block[5], i_req.block_fnum_high};
    end

    // Next state and register writes per kind
    always_comb begin
        o_state  = i_state;
        o_writes = '0;
        case (i_req.kind)
            KIND_TICK: begin
                if (i_state.mode == MODE_SLIDE) begin
                    o_state.slide_phase = slide_sum[7:0];
                    if (slide_sum[8]) begin
                        o_state.freq_low  = slide_adj[7:0];
                        o_state.key_block = {2'b0, i_state.key_block[5], oct_n,
                                             slide_adj[9:8]};
                        o_writes.first_valid  = 1'b1;
                        o_writes.second_valid = 1'b1;
                    end
                end else if (i_state.mode == MODE_VIBRATO) begin
                    if (i_state.vib_wait != 8'd0) begin
                        o_state.vib_wait = i_state.vib_wait - 8'd1;
                    end else begin
                        o_state.vib_phase = vib_sum[7:0];
                        if (vib_sum[8]) begin
                            o_state.vib_countdown = vib_cd_n;
                            o_state.vib_inc       = vib_inc_n;
                            o_state.freq_low      = vib_f[7:0];
                            o_state.key_block     = {i_state.key_block[7:2], 2'b0}
                                                    | vib_f[15:8];
                            o_writes.first_valid  = 1'b1;
                            o_writes.second_valid = 1'b1;
                        end
                    end
                end
                o_writes.first_addr   = addr_freq;
                o_writes.first_value  = o_state.freq_low;
                o_writes.second_addr  = addr_key;
                o_writes.second_value = o_state.key_block;
            end
            KIND_SET_FREQ: begin
                o_state.freq_low      = i_req.fnum_low;
                o_state.key_block     = set_key_byte;
                o_writes.first_valid  = 1'b1;
                o_writes.first_addr   = addr_freq;
                o_writes.first_value  = i_req.fnum_low;
                o_writes.second_valid = 1'b1;
                o_writes.second_addr  = addr_key;
                o_writes.second_value = set_key_byte;
            end
            KIND_KEY_ON: begin
                o_state.key_block    = key_on_byte;
                o_state.vib_inc      = {8'b0, freq_shifted[7:0]};
                o_state.vib_wait     = i_state.vib_delay;
                o_writes.first_valid = 1'b1;
                o_writes.first_addr  = addr_key;
                o_writes.first_value = key_on_byte;
            end
            KIND_KEY_OFF: begin
                if (!(i_rhythm_mode && (i_req.channel >= 4'd6))) begin
                    o_state.key_block    = key_off_byte;
                    o_writes.first_valid = 1'b1;
                    o_writes.first_addr  = addr_key;
                    o_writes.first_value = key_off_byte;
                end
            end
            KIND_SLIDE: begin
                o_state.slide_rate  = i_req.param_a;
                o_state.slide_phase = 8'hFF;
                o_state.slide_inc   = i_req.slide_step;
                o_state.mode        = MODE_SLIDE;
            end
            KIND_VIBRATO: begin
                o_state.vib_rate      = i_req.param_a;
                o_state.vib_range     = i_req.param_b;
                o_state.vib_countdown = i_req.param_c + 8'd1;
                o_state.vib_period    = {i_req.param_c[6:0], 1'b0};
                o_state.vib_delay     = i_req.param_d;
                o_state.mode          = MODE_VIBRATO;
            end
            KIND_RM_SLIDE: begin
                o_state.slide_inc = 16'd0;
                o_state.mode      = MODE_NONE;
            end
            KIND_RM_VIBRATO: begin
                o_state.mode = MODE_NONE;
            end
            default: begin
                o_state.mode = MODE_NONE;
            end
        endcase
    end

endmodule
